### sv/imhol_pkg.sv
// Package for the indexed min-heap open list: sizes, codes, entry types and
// the heap ordering function. No dependencies.
package imhol_pkg;

  localparam int unsigned HeapDepth = 1024;
  localparam int unsigned NodeSpace = 4096;
  localparam int unsigned CostBits  = 16;
  localparam int unsigned NodeBits  = 12;
  localparam int unsigned SlotBits  = $clog2(HeapDepth);
  localparam int unsigned CountBits = SlotBits + 1;
  localparam int unsigned NodeAw    = $clog2(NodeSpace);
  localparam int unsigned FBits     = CostBits + 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef struct packed {
    logic [NodeBits-1:0] node;
    logic [CostBits-1:0] g;
    logic [CostBits-1:0] h;
  } entry_t;

  typedef struct packed {
    logic                valid;
    logic [SlotBits-1:0] slot;
  } pos_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_START,
    CMD_QUERY,
    CMD_SET_FULL,
    CMD_SET_ABSENT,
    CMD_SET_EMPTY,
    CMD_INS_SETUP,
    CMD_UPD_READ,
    CMD_UPD_SET,
    CMD_RM_ROOT,
    CMD_RM_LAST,
    CMD_UP_READ,
    CMD_UP_MOVE,
    CMD_PLACE,
    CMD_DN_READL,
    CMD_DN_LATCHL,
    CMD_DN_PICKR,
    CMD_DN_MOVE,
    CMD_OUT_LOAD
  } dp_cmd_e;

  typedef struct packed {
    mode_e mode;
    logic  pos_valid;
    logic  full;
    logic  count_zero;
    logic  g_lower;
    logic  k_root;
    logic  cur_before_rd;
    logic  child_before_cur;
    logic  l_in;
    logic  r_in;
    logic  clr_done;
    logic  out_free;
  } dp_sts_t;

  function automatic logic [FBits-1:0] f_of(entry_t e);
    return {1'b0, e.g} + {1'b0, e.h};
  endfunction

  // Heap order: smaller f first, and on equal f the smaller g.
  function automatic logic before_f(entry_t a, entry_t b);
    logic [FBits-1:0] fa;
    logic [FBits-1:0] fb;
    fa = f_of(a);
    fb = f_of(b);
    return (fa < fb) || ((fa == fb) && (a.g < b.g));
  endfunction

endpackage

### sv/indexed_min_heap_open_list_core.sv
// Top level of the indexed min-heap open list: controller plus datapath.
// Uses imhol_pkg, imhol_ctrl and imhol_datapath.
//
//   channel | signals                        | direction
//   input   | in_valid_i, in_stall_o, fields | mode, node id, g, h in
//   output  | out_valid_o, out_stall_i, flds | status, removed entry, counts
//
// A query result is loaded via the dispatch, finish and top states. Insert
// and update climb one heap level per parent read and compare; remove
// descends one level per read of the left child, of the right child when
// present, and a compare. The single read port of the heap RAM sets these
// steps. After reset the position table is cleared, one entry a cycle, all
// 4096 entries; no transaction is accepted meanwhile.
// A finished result waits in the output register while the next input
// transaction is accepted, from the cycle after the result is loaded.
module indexed_min_heap_open_list_core import imhol_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [NodeBits-1:0]  node_id_i,
  input  logic [CostBits-1:0]  g_cost_i,
  input  logic [CostBits-1:0]  h_cost_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [NodeBits-1:0]  out_node_id_o,
  output logic [CostBits-1:0]  out_g_o,
  output logic [CostBits-1:0]  out_h_o,
  output logic [FBits-1:0]     out_f_o,
  output logic                 improved_o,
  output logic                 present_o,
  output logic [FBits-1:0]     top_f_o,
  output logic                 is_empty_o,
  output logic [CountBits-1:0] entry_count_o,
  output logic [CountBits-1:0] peak_count_o
);

  dp_cmd_e cmd;
  dp_sts_t sts;

  imhol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imhol_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .node_id_i     (node_id_i),
    .g_cost_i      (g_cost_i),
    .h_cost_i      (h_cost_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_node_id_o (out_node_id_o),
    .out_g_o       (out_g_o),
    .out_h_o       (out_h_o),
    .out_f_o       (out_f_o),
    .improved_o    (improved_o),
    .present_o     (present_o),
    .top_f_o       (top_f_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o),
    .peak_count_o  (peak_count_o)
  );

endmodule

### sv/imhol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imhol_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/imhol_datapath.sv
// Datapath of the open list: heap and position RAMs, the moving entry,
// counters and result registers. Uses imhol_pkg and imhol_ram.
module imhol_datapath import imhol_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_e               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [1:0]            mode_i,
  input  logic [NodeBits-1:0]   node_id_i,
  input  logic [CostBits-1:0]   g_cost_i,
  input  logic [CostBits-1:0]   h_cost_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [NodeBits-1:0]   out_node_id_o,
  output logic [CostBits-1:0]   out_g_o,
  output logic [CostBits-1:0]   out_h_o,
  output logic [FBits-1:0]      out_f_o,
  output logic                  improved_o,
  output logic                  present_o,
  output logic [FBits-1:0]      top_f_o,
  output logic                  is_empty_o,
  output logic [CountBits-1:0]  entry_count_o,
  output logic [CountBits-1:0]  peak_count_o
);

  mode_e                mode_q;
  logic [NodeBits-1:0]  node_q;
  logic [CostBits-1:0]  g_q, h_q;
  entry_t               cur_q, cur_d, child_q, child_d, rm_q, rm_d;
  logic [SlotBits-1:0]  k_q, k_d, m_q, m_d;
  logic [CountBits-1:0] count_q, count_d, peak_q, peak_d;
  logic [NodeAw-1:0]    clr_q;
  status_e              res_st_q, res_st_d;
  logic                 impr_q, impr_d, pres_q, pres_d;

  logic                 out_valid_q;
  status_e              o_st_q;
  entry_t               o_ent_q;
  logic                 o_impr_q, o_pres_q, o_empty_q;
  logic [FBits-1:0]     o_top_q;
  logic [CountBits-1:0] o_cnt_q, o_peak_q;

  logic                 hp_we, ps_we;
  logic [SlotBits-1:0]  hp_waddr, hp_raddr;
  entry_t               hp_wdata, hp_rd;
  logic [NodeAw-1:0]    ps_waddr;
  pos_t                 ps_wdata, ps_rd;

  logic [SlotBits-1:0]  parent;
  logic [CountBits:0]   l_idx, r_idx;

  assign parent = (k_q - SlotBits'(1)) >> 1;
  assign l_idx  = {1'b0, k_q, 1'b1};
  assign r_idx  = l_idx + (CountBits+1)'(1);

  imhol_ram #(.Width($bits(entry_t)), .Depth(HeapDepth)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (hp_we),
    .waddr_i (hp_waddr),
    .wdata_i (hp_wdata),
    .raddr_i (hp_raddr),
    .rdata_o (hp_rd)
  );

  imhol_ram #(.Width($bits(pos_t)), .Depth(NodeSpace)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (ps_waddr),
    .wdata_i (ps_wdata),
    .raddr_i (node_id_i[NodeAw-1:0]),
    .rdata_o (ps_rd)
  );

  always_comb begin
    hp_raddr = '0;
    hp_we    = 1'b0;
    hp_waddr = k_q;
    hp_wdata = cur_q;
    ps_we    = 1'b0;
    ps_waddr = cur_q.node[NodeAw-1:0];
    ps_wdata = '{valid: 1'b1, slot: k_q};
    cur_d    = cur_q;
    child_d  = child_q;
    rm_d     = rm_q;
    k_d      = k_q;
    m_d      = m_q;
    count_d  = count_q;
    peak_d   = peak_q;
    res_st_d = res_st_q;
    impr_d   = impr_q;
    pres_d   = pres_q;
    case (cmd_i)
      CMD_CLEAR: begin
        ps_we    = 1'b1;
        ps_waddr = clr_q;
        ps_wdata = '0;
      end
      CMD_START: begin
        res_st_d = ST_OK;
        impr_d   = 1'b0;
        pres_d   = 1'b0;
        rm_d     = '0;
      end
      CMD_QUERY:      pres_d   = ps_rd.valid;
      CMD_SET_FULL:   res_st_d = ST_FULL;
      CMD_SET_ABSENT: res_st_d = ST_ABSENT;
      CMD_SET_EMPTY:  res_st_d = ST_EMPTY;
      CMD_INS_SETUP: begin
        cur_d   = '{node: node_q, g: g_q, h: h_q};
        k_d     = count_q[SlotBits-1:0];
        count_d = count_q + CountBits'(1);
        if (count_d > peak_q) begin
          peak_d = count_d;
        end
      end
      CMD_UPD_READ: begin
        hp_raddr = ps_rd.slot;
        k_d      = ps_rd.slot;
      end
      CMD_UPD_SET: begin
        cur_d  = '{node: node_q, g: g_q, h: hp_rd.h};
        impr_d = 1'b1;
      end
      CMD_RM_ROOT: begin
        rm_d     = hp_rd;
        count_d  = count_q - CountBits'(1);
        hp_raddr = count_d[SlotBits-1:0];
      end
      CMD_RM_LAST: begin
        cur_d    = hp_rd;
        k_d      = '0;
        ps_we    = 1'b1;
        ps_waddr = rm_q.node[NodeAw-1:0];
        ps_wdata = '0;
      end
      CMD_UP_READ: hp_raddr = parent;
      CMD_UP_MOVE: begin
        hp_we    = 1'b1;
        hp_wdata = hp_rd;
        ps_we    = 1'b1;
        ps_waddr = hp_rd.node[NodeAw-1:0];
        k_d      = parent;
      end
      CMD_PLACE: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
      end
      CMD_DN_READL: hp_raddr = l_idx[SlotBits-1:0];
      CMD_DN_LATCHL: begin
        child_d  = hp_rd;
        m_d      = l_idx[SlotBits-1:0];
        hp_raddr = r_idx[SlotBits-1:0];
      end
      CMD_DN_PICKR: begin
        if (!before_f(child_q, hp_rd)) begin
          child_d = hp_rd;
          m_d     = r_idx[SlotBits-1:0];
        end
      end
      CMD_DN_MOVE: begin
        hp_we    = 1'b1;
        hp_wdata = child_q;
        ps_we    = 1'b1;
        ps_waddr = child_q.node[NodeAw-1:0];
        k_d      = m_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      peak_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      peak_q  <= peak_d;
      if (cmd_i == CMD_CLEAR) begin
        clr_q <= clr_q + NodeAw'(1);
      end
      if (cmd_i == CMD_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    child_q  <= child_d;
    rm_q     <= rm_d;
    k_q      <= k_d;
    m_q      <= m_d;
    res_st_q <= res_st_d;
    impr_q   <= impr_d;
    pres_q   <= pres_d;
    if (cmd_i == CMD_START) begin
      mode_q <= mode_e'(mode_i);
      node_q <= node_id_i;
      g_q    <= g_cost_i;
      h_q    <= h_cost_i;
    end
    if (cmd_i == CMD_OUT_LOAD) begin
      o_st_q    <= res_st_q;
      o_ent_q   <= rm_q;
      o_impr_q  <= impr_q;
      o_pres_q  <= pres_q;
      o_empty_q <= (count_q == '0);
      o_top_q   <= (count_q == '0) ? '0 : f_of(hp_rd);
      o_cnt_q   <= count_q;
      o_peak_q  <= peak_q;
    end
  end

  assign sts_o = '{
    mode:             mode_q,
    pos_valid:        ps_rd.valid,
    full:             (count_q == CountBits'(HeapDepth)),
    count_zero:       (count_q == '0),
    g_lower:          (g_q < hp_rd.g),
    k_root:           (k_q == '0),
    cur_before_rd:    before_f(cur_q, hp_rd),
    child_before_cur: before_f(child_q, cur_q),
    l_in:             (l_idx < {1'b0, count_q}),
    r_in:             (r_idx < {1'b0, count_q}),
    clr_done:         (clr_q == '1),
    out_free:         (!out_valid_q || !out_stall_i)
  };

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_st_q;
  assign out_node_id_o = o_ent_q.node;
  assign out_g_o       = o_ent_q.g;
  assign out_h_o       = o_ent_q.h;
  assign out_f_o       = f_of(o_ent_q);
  assign improved_o    = o_impr_q;
  assign present_o     = o_pres_q;
  assign top_f_o       = o_top_q;
  assign is_empty_o    = o_empty_q;
  assign entry_count_o = o_cnt_q;
  assign peak_count_o  = o_peak_q;

endmodule

### sv/imhol_ctrl.sv
// Controller state machine of the open list: sequences the RAM reads,
// compares and writes of each operation. Uses imhol_pkg.
module imhol_ctrl import imhol_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_e cmd_o
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DISPATCH = 13'b0000000000100,
    S_UPD_CHK  = 13'b0000000001000,
    S_RM_LAST  = 13'b0000000010000,
    S_UP       = 13'b0000000100000,
    S_UP_CMP   = 13'b0000001000000,
    S_DN       = 13'b0000010000000,
    S_DN_L     = 13'b0000100000000,
    S_DN_R     = 13'b0001000000000,
    S_DN_CMP   = 13'b0010000000000,
    S_FIN      = 13'b0100000000000,
    S_TOP      = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_START;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FIN;
        case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.full) begin
              cmd_o = CMD_SET_FULL;
            end else if (!sts_i.pos_valid) begin
              cmd_o   = CMD_INS_SETUP;
              state_d = S_UP;
            end
          end
          MODE_REMOVE: begin
            if (sts_i.count_zero) begin
              cmd_o = CMD_SET_EMPTY;
            end else begin
              cmd_o   = CMD_RM_ROOT;
              state_d = S_RM_LAST;
            end
          end
          MODE_UPDATE: begin
            if (!sts_i.pos_valid) begin
              cmd_o = CMD_SET_ABSENT;
            end else begin
              cmd_o   = CMD_UPD_READ;
              state_d = S_UPD_CHK;
            end
          end
          default: cmd_o = CMD_QUERY;
        endcase
      end
      S_UPD_CHK: begin
        state_d = S_FIN;
        if (sts_i.g_lower) begin
          cmd_o   = CMD_UPD_SET;
          state_d = S_UP;
        end
      end
      S_RM_LAST: begin
        cmd_o   = CMD_RM_LAST;
        state_d = sts_i.count_zero ? S_FIN : S_DN;
      end
      S_UP: begin
        if (sts_i.k_root) begin
          cmd_o   = CMD_PLACE;
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_UP_READ;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.cur_before_rd) begin
          cmd_o   = CMD_UP_MOVE;
          state_d = S_UP;
        end else begin
          cmd_o   = CMD_PLACE;
          state_d = S_FIN;
        end
      end
      S_DN: begin
        if (sts_i.l_in) begin
          cmd_o   = CMD_DN_READL;
          state_d = S_DN_L;
        end else begin
          cmd_o   = CMD_PLACE;
          state_d = S_FIN;
        end
      end
      S_DN_L: begin
        cmd_o   = CMD_DN_LATCHL;
        state_d = sts_i.r_in ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin
        cmd_o   = CMD_DN_PICKR;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.child_before_cur) begin
          cmd_o   = CMD_DN_MOVE;
          state_d = S_DN;
        end else begin
          cmd_o   = CMD_PLACE;
          state_d = S_FIN;
        end
      end
      // The root is read here so that its f is ready in S_TOP.
      S_FIN: state_d = S_TOP;
      S_TOP: begin
        if (sts_i.out_free) begin
          cmd_o   = CMD_OUT_LOAD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### sv/imhol_checker.sv
// Port-level checks for the open list core, attached by a bind.
// Uses imhol_pkg.
module imhol_checker import imhol_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic [FBits-1:0]     top_f_o,
  input logic                 is_empty_o,
  input logic [CountBits-1:0] entry_count_o,
  input logic [CountBits-1:0] peak_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_count_o))
    else $error("Output transaction changed while stalled.");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("Empty flag disagrees with entry count.");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_count_o >= entry_count_o))
    else $error("Peak count below entry count.");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == CountBits'(HeapDepth))
    else $error("Full status without a full heap.");

  a_top_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> top_f_o == '0)
    else $error("Top f nonzero on an empty heap.");

endmodule

bind indexed_min_heap_open_list_core imhol_checker u_imhol_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .top_f_o       (top_f_o),
  .is_empty_o    (is_empty_o),
  .entry_count_o (entry_count_o),
  .peak_count_o  (peak_count_o)
);

### tb/tb_indexed_min_heap_open_list_core.sv
// Testbench for indexed_min_heap_open_list_core: directed table, then random
// phases checked against a behavioral heap predictor. Depends on imhol_pkg.
`timescale 1ns / 1ps

module tb_indexed_min_heap_open_list_core;
  import imhol_pkg::*;

  typedef struct {
    status_e              status;
    logic [NodeBits-1:0]  node;
    logic [CostBits-1:0]  g;
    logic [CostBits-1:0]  h;
    logic [FBits-1:0]     f;
    logic                 improved;
    logic                 present;
    logic [FBits-1:0]     top_f;
    logic                 empty;
    logic [CountBits-1:0] count;
    logic [CountBits-1:0] peak;
  } heap_result_t;

  typedef struct {
    mode_e                mode;
    logic [NodeBits-1:0]  node;
    logic [CostBits-1:0]  g;
    logic [CostBits-1:0]  h;
    bit                   typed;
    status_e              st;
    logic [CountBits-1:0] cnt;
  } table_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           mode_i = '0;
  logic [NodeBits-1:0]  node_id_i = '0;
  logic [CostBits-1:0]  g_cost_i = '0;
  logic [CostBits-1:0]  h_cost_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic [NodeBits-1:0]  out_node_id_o;
  logic [CostBits-1:0]  out_g_o;
  logic [CostBits-1:0]  out_h_o;
  logic [FBits-1:0]     out_f_o;
  logic                 improved_o;
  logic                 present_o;
  logic [FBits-1:0]     top_f_o;
  logic                 is_empty_o;
  logic [CountBits-1:0] entry_count_o;
  logic [CountBits-1:0] peak_count_o;

  indexed_min_heap_open_list_core u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: heap array, node-to-slot table (slot + 1, 0 = absent).
  entry_t       open_heap [HeapDepth];
  int unsigned  slot_plus1 [NodeSpace];
  int unsigned  heap_count;
  int unsigned  heap_peak;
  heap_result_t expected_results[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  full_hits = 0;
  int  gap_max = 0;
  int  stall_pct = 0;
  int  burst_left = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  function automatic logic [FBits-1:0] cost_f(entry_t e);
    return {1'b0, e.g} + {1'b0, e.h};
  endfunction

  function automatic bit ranks_ahead(int unsigned a, int unsigned b);
    logic [FBits-1:0] fa;
    logic [FBits-1:0] fb;
    fa = cost_f(open_heap[a]);
    fb = cost_f(open_heap[b]);
    if (fa == fb) return open_heap[a].g < open_heap[b].g;
    return fa < fb;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    entry_t t;
    if (a == b) return;
    t = open_heap[a];
    open_heap[a] = open_heap[b];
    open_heap[b] = t;
    slot_plus1[open_heap[a].node] = a + 1;
    slot_plus1[open_heap[b].node] = b + 1;
  endfunction

  function automatic void climb(int unsigned k);
    int unsigned p;
    while (k >= 1) begin
      p = (k - 1) / 2;
      if (!ranks_ahead(k, p)) break;
      swap_entries(k, p);
      k = p;
    end
  endfunction

  function automatic void descend(int unsigned k);
    int unsigned l;
    int unsigned m;
    while (2 * k + 1 < heap_count) begin
      l = 2 * k + 1;
      m = l;
      if (l + 1 < heap_count && !ranks_ahead(l, l + 1)) m = l + 1;
      if (!ranks_ahead(m, k)) break;
      swap_entries(m, k);
      k = m;
    end
  endfunction

  function automatic heap_result_t apply_op(mode_e mode, logic [NodeBits-1:0] node,
                                            logic [CostBits-1:0] g,
                                            logic [CostBits-1:0] h);
    heap_result_t r;
    entry_t e;
    int unsigned s;
    r = '{ST_OK, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0, '0};
    case (mode)
      MODE_INSERT: begin
        if (heap_count >= HeapDepth) begin
          r.status = ST_FULL;
        end else if (slot_plus1[node] == 0) begin
          s = heap_count;
          open_heap[s] = '{node: node, g: g, h: h};
          slot_plus1[node] = s + 1;
          heap_count++;
          if (heap_count > heap_peak) heap_peak = heap_count;
          climb(s);
        end
      end
      MODE_REMOVE: begin
        if (heap_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          swap_entries(0, heap_count - 1);
          e = open_heap[heap_count - 1];
          heap_count--;
          descend(0);
          slot_plus1[e.node] = 0;
          r.node = e.node;
          r.g = e.g;
          r.h = e.h;
          r.f = cost_f(e);
        end
      end
      MODE_UPDATE: begin
        if (slot_plus1[node] == 0) begin
          r.status = ST_ABSENT;
        end else begin
          s = slot_plus1[node] - 1;
          if (g < open_heap[s].g) begin
            open_heap[s].g = g;
            r.improved = 1'b1;
            climb(s);
          end
        end
      end
      default: r.present = slot_plus1[node] != 0;
    endcase
    r.top_f = heap_count != 0 ? cost_f(open_heap[0]) : '0;
    r.empty = heap_count == 0;
    r.count = CountBits'(heap_count);
    r.peak = CountBits'(heap_peak);
    return r;
  endfunction

  // Offers one transaction, honoring the burst/gap pattern, and predicts it
  // once accepted.
  task automatic offer(mode_e mode, logic [NodeBits-1:0] node, logic [CostBits-1:0] g,
                       logic [CostBits-1:0] h, bit typed = 1'b0,
                       status_e st = ST_OK, logic [CountBits-1:0] cnt = '0);
    heap_result_t r;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    mode_i = mode;
    node_id_i = node;
    g_cost_i = g;
    h_cost_i = h;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_op(mode, node, g, h);
    if (r.status == ST_FULL) full_hits++;
    if (typed) begin
      r.status = st;
      r.count = cnt;
      r.empty = cnt == 0;
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Receiver stall: random pattern, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    heap_result_t w;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", status_o, 0);
      end else begin
        w = expected_results.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (out_node_id_o !== w.node) report_mismatch("out_node_id", out_node_id_o, w.node);
        if (out_g_o !== w.g) report_mismatch("out_g", out_g_o, w.g);
        if (out_h_o !== w.h) report_mismatch("out_h", out_h_o, w.h);
        if (out_f_o !== w.f) report_mismatch("out_f", out_f_o, w.f);
        if (improved_o !== w.improved) report_mismatch("improved", improved_o, w.improved);
        if (present_o !== w.present) report_mismatch("present", present_o, w.present);
        if (top_f_o !== w.top_f) report_mismatch("top_f", top_f_o, w.top_f);
        if (is_empty_o !== w.empty) report_mismatch("is_empty", is_empty_o, w.empty);
        if (entry_count_o !== w.count) report_mismatch("entry_count", entry_count_o, w.count);
        if (peak_count_o !== w.peak) report_mismatch("peak_count", peak_count_o, w.peak);
      end
    end
  end

  function automatic logic [NodeBits-1:0] pick_node();
    return ($urandom_range(3) != 0) ? NodeBits'($urandom_range(63)) : NodeBits'($urandom);
  endfunction

  task automatic random_mix(int n, int w_ins, int w_rem, int w_upd);
    int roll;
    mode_e m;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < w_ins) m = MODE_INSERT;
      else if (roll < w_ins + w_rem) m = MODE_REMOVE;
      else if (roll < w_ins + w_rem + w_upd) m = MODE_UPDATE;
      else m = MODE_QUERY;
      offer(m, pick_node(), CostBits'($urandom), CostBits'($urandom));
    end
  endtask

  initial begin
    table_row_t rows[$];
    int unsigned base;
    int unsigned stride;
    for (int i = 0; i < NodeSpace; i++) slot_plus1[i] = 0;
    heap_count = 0;
    heap_peak = 0;

    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b1, ST_EMPTY, 11'd0});
    rows.insert(rows.size(), '{MODE_QUERY, 12'd5, 16'd0, 16'd0, 1'b1, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_UPDATE, 12'd5, 16'd1, 16'd0, 1'b1, ST_ABSENT, 11'd0});
    rows.insert(rows.size(), '{MODE_INSERT, 12'd0, 16'd0, 16'd0, 1'b1, ST_OK, 11'd1});
    rows.insert(rows.size(), '{MODE_INSERT, 12'hfff, 16'hffff, 16'hffff, 1'b1, ST_OK, 11'd2});
    rows.insert(rows.size(), '{MODE_INSERT, 12'd0, 16'd9, 16'd9, 1'b1, ST_OK, 11'd2});
    rows.insert(rows.size(), '{MODE_QUERY, 12'hfff, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_UPDATE, 12'hfff, 16'hfffe, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_UPDATE, 12'hfff, 16'hffff, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_UPDATE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    // Equal f: the entry with the smaller g has to come out first.
    rows.insert(rows.size(), '{MODE_INSERT, 12'd100, 16'd10, 16'd5, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_INSERT, 12'd200, 16'd5, 16'd10, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_INSERT, 12'd300, 16'd20, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    // A removed node that comes back must be found again by update.
    rows.insert(rows.size(), '{MODE_INSERT, 12'd200, 16'd50, 16'd50, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_UPDATE, 12'd200, 16'd1, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_QUERY, 12'd200, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b0, ST_OK, 11'd0});
    rows.insert(rows.size(), '{MODE_REMOVE, 12'd0, 16'd0, 16'd0, 1'b1, ST_EMPTY, 11'd0});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gap_max = 3;
    stall_pct = 30;
    foreach (rows[i]) offer(rows[i].mode, rows[i].node, rows[i].g, rows[i].h,
                            rows[i].typed, rows[i].st, rows[i].cnt);

    // Back to back, no receiver stall.
    gap_max = 0;
    stall_pct = 0;
    random_mix(100, 45, 20, 20);
    gap_max = 8;
    stall_pct = 50;
    random_mix(100, 40, 25, 20);

    // Sender waits for the block to drain before filling the heap.
    idle_sender();
    wait (expected_results.size() == 0);

    // Fill to capacity under a long receiver hold-off, then hit the full case.
    gap_max = 2;
    stall_pct = 10;
    hold_req = 1'b1;
    base = $urandom_range(NodeSpace - 1);
    stride = 2 * $urandom_range(1, 200) + 1;
    for (int unsigned i = 0; i < HeapDepth + 12; i++) begin
      offer(MODE_INSERT, NodeBits'(base + i * stride), CostBits'($urandom),
            CostBits'($urandom));
      if ($urandom_range(15) == 0) begin
        offer(MODE_UPDATE, pick_node(), CostBits'($urandom), 16'd0);
      end
    end

    gap_max = 5;
    stall_pct = 35;
    random_mix(200, 10, 60, 20);
    idle_sender();

    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d results; heap peak %0d entries, %0d inserts refused as full.",
             results_seen, heap_peak, full_hits);
    $display("Checked insert, remove, update and query against the heap predictor.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d transactions outstanding.", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
